@@ hdl/pjq_pkg.sv @@
// pjq_pkg: shared types, constants and codes of the priority job queue.
// No dependencies; imported by pjq_ctrl, priority_job_queue and the testbench.
`default_nettype none

package pjq_pkg;

  localparam int QUEUE_DEPTH = 16;
  localparam int IDX_W       = $clog2(QUEUE_DEPTH);
  localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);
  localparam int ENTRY_W     = 56;

  // request codes
  localparam logic [2:0] FN_ENQ    = 3'd0;
  localparam logic [2:0] FN_DEQ    = 3'd1;
  localparam logic [2:0] FN_CMPL   = 3'd2;
  localparam logic [2:0] FN_CANCEL = 3'd3;
  localparam logic [2:0] FN_PROC   = 3'd4;
  localparam logic [2:0] FN_CLEAR  = 3'd5;

  // result status codes
  localparam logic [1:0] RS_OK     = 2'd0;
  localparam logic [1:0] RS_NOT_OK = 2'd1;
  localparam logic [1:0] RS_FULL   = 2'd2;
  localparam logic [1:0] RS_EMPTY  = 2'd3;

  localparam logic [3:0] MAX_GOOD_TYPE = 4'd7;

  typedef enum logic [1:0] {
    ES_FREE,
    ES_QUEUED,
    ES_ACTIVE
  } estat_t;

  typedef struct packed {
    logic [31:0] id;
    logic [3:0]  jtype;
    logic [3:0]  prio;
    logic [15:0] block;
  } entry_t;

  typedef struct packed {
    logic [2:0]  func;
    logic [3:0]  job_type;
    logic [3:0]  priority_req;
    logic [15:0] block_id;
    logic [31:0] job_id;
    logic        job_failed;
  } in_t;

  typedef struct packed {
    logic [1:0]       status;
    logic             job_valid;
    logic [31:0]      out_job_id;
    logic [3:0]       out_job_type;
    logic [3:0]       out_priority;
    logic [15:0]      out_block_id;
    logic             job_outcome;
    logic             last;
    logic [CNT_W-1:0] queued_count;
    logic [CNT_W-1:0] active_count;
    logic [31:0]      completed_count;
    logic [31:0]      failed_count;
  } out_t;

  typedef enum logic [4:0] {
    S_IDLE,
    S_DISPATCH,
    S_INS_RDO,
    S_INS_RDE,
    S_INS_CHK,
    S_POP_O,
    S_POP_E,
    S_SH_RD,
    S_SH_WR,
    S_CP_RD,
    S_CP_CHK,
    S_CN_RDO,
    S_CN_RDE,
    S_CN_CHK,
    S_CL_RDO,
    S_CL_RDE,
    S_CL_CAP,
    S_EMIT
  } state_t;

endpackage

`default_nettype wire

@@ hdl/pjq_ram.sv @@
// pjq_ram: generic single-write, single-read synchronous RAM, registered read.
// No dependencies.
`default_nettype none

module pjq_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

@@ hdl/pjq_ctrl.sv @@
// pjq_ctrl: command sequencer of the job queue; walks the entry and order RAMs.
// Depends on pjq_pkg.
`default_nettype none

module pjq_ctrl
  import pjq_pkg::*;
(
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             in_valid,
  output logic                  in_ready,
  input  wire in_t              in_data,
  input  wire logic             cfg_we,
  input  wire logic             cfg_wdata,
  output logic                  emit_valid,
  output out_t                  emit_data,
  input  wire logic             emit_room,
  output logic                  e_we,
  output logic [IDX_W-1:0]      e_waddr,
  output entry_t                e_wdata,
  output logic [IDX_W-1:0]      e_raddr,
  input  wire entry_t           e_rdata,
  output logic                  o_we,
  output logic [IDX_W-1:0]      o_waddr,
  output logic [IDX_W-1:0]      o_wdata,
  output logic [IDX_W-1:0]      o_raddr,
  input  wire logic [IDX_W-1:0] o_rdata
);

  state_t           state_r, state_nxt;
  in_t              cmd_r;
  logic             paused_r;
  logic [CNT_W-1:0] qlen_r, act_r, i_r, len_r;
  logic [31:0]      next_id_r, succ_r, fail_r;
  estat_t           estat_r [QUEUE_DEPTH];
  logic [IDX_W-1:0] slot_r, od_r;
  entry_t           ent_r;
  logic [1:0]       res_status_r;
  logic             res_jv_r, res_outc_r, res_last_r, clr_r;

  logic             free_found;
  logic [IDX_W-1:0] free_idx;
  logic             full;
  logic             ins_stop;
  logic             i_at_end;

  always_comb begin
    free_found = 1'b0;
    free_idx   = '0;
    for (int k = QUEUE_DEPTH - 1; k >= 0; k--) begin
      if (estat_r[k] == ES_FREE) begin
        free_found = 1'b1;
        free_idx   = IDX_W'(k);
      end
    end
  end

  assign full     = !free_found || (qlen_r >= CNT_W'(QUEUE_DEPTH));
  assign ins_stop = e_rdata.prio >= cmd_r.priority_req;
  assign i_at_end = i_r >= len_r;

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE:     if (in_valid) state_nxt = S_DISPATCH;
      S_DISPATCH: begin
        priority case (cmd_r.func)
          FN_ENQ:    state_nxt = full ? S_EMIT : S_INS_RDO;
          FN_DEQ:    state_nxt = (qlen_r == '0) ? S_EMIT : S_POP_O;
          FN_PROC:   state_nxt = (paused_r || qlen_r == '0) ? S_EMIT : S_POP_O;
          FN_CMPL:   state_nxt = S_CP_RD;
          FN_CANCEL: state_nxt = S_CN_RDO;
          FN_CLEAR:  state_nxt = (qlen_r == '0) ? S_EMIT : S_CL_RDO;
          default:   state_nxt = S_EMIT;
        endcase
      end
      S_INS_RDO:  state_nxt = (i_r == '0) ? S_EMIT : S_INS_RDE;
      S_INS_RDE:  state_nxt = S_INS_CHK;
      S_INS_CHK:  state_nxt = ins_stop ? S_EMIT : S_INS_RDO;
      S_POP_O:    state_nxt = S_POP_E;
      S_POP_E:    state_nxt = S_SH_RD;
      S_SH_RD:    state_nxt = i_at_end ? S_EMIT : S_SH_WR;
      S_SH_WR:    state_nxt = S_SH_RD;
      S_CP_RD: begin
        priority if (i_r == CNT_W'(QUEUE_DEPTH)) state_nxt = S_EMIT;
        else if (estat_r[i_r[IDX_W-1:0]] == ES_ACTIVE) state_nxt = S_CP_CHK;
        else state_nxt = S_CP_RD;
      end
      S_CP_CHK:   state_nxt = (e_rdata.id == cmd_r.job_id) ? S_EMIT : S_CP_RD;
      S_CN_RDO:   state_nxt = i_at_end ? S_EMIT : S_CN_RDE;
      S_CN_RDE:   state_nxt = S_CN_CHK;
      S_CN_CHK:   state_nxt = (e_rdata.id == cmd_r.job_id) ? S_SH_RD : S_CN_RDO;
      S_CL_RDO:   state_nxt = S_CL_RDE;
      S_CL_RDE:   state_nxt = S_CL_CAP;
      S_CL_CAP:   state_nxt = S_EMIT;
      S_EMIT: begin
        if (emit_room) state_nxt = (clr_r && !res_last_r) ? S_CL_RDO : S_IDLE;
      end
      default:    state_nxt = S_IDLE;
    endcase
  end

  // RAM ports and result
  always_comb begin
    e_we    = 1'b0;
    e_waddr = free_idx;
    e_wdata = '{id: next_id_r, jtype: cmd_r.job_type, prio: cmd_r.priority_req,
                block: cmd_r.block_id};
    e_raddr = '0;
    o_we    = 1'b0;
    o_waddr = '0;
    o_wdata = slot_r;
    o_raddr = '0;
    unique case (state_r)
      S_DISPATCH: e_we = (cmd_r.func == FN_ENQ) && !full;
      S_INS_RDO: begin
        o_raddr = IDX_W'(i_r - 1'b1);
        o_we    = (i_r == '0);
      end
      S_INS_RDE:  e_raddr = o_rdata;
      S_INS_CHK: begin
        o_we    = 1'b1;
        o_waddr = i_r[IDX_W-1:0];
        o_wdata = ins_stop ? slot_r : od_r;
      end
      S_POP_O:    e_raddr = o_rdata;
      S_SH_RD:    o_raddr = i_r[IDX_W-1:0];
      S_SH_WR: begin
        o_we    = 1'b1;
        o_waddr = IDX_W'(i_r - 1'b1);
        o_wdata = o_rdata;
      end
      S_CP_RD:    e_raddr = i_r[IDX_W-1:0];
      S_CN_RDO:   o_raddr = i_r[IDX_W-1:0];
      S_CN_RDE:   e_raddr = o_rdata;
      S_CL_RDO:   o_raddr = i_r[IDX_W-1:0];
      S_CL_RDE:   e_raddr = o_rdata;
      default: ;
    endcase
  end

  assign in_ready   = (state_r == S_IDLE);
  assign emit_valid = (state_r == S_EMIT);

  always_comb begin
    emit_data                 = '0;
    emit_data.status          = res_status_r;
    emit_data.job_valid       = res_jv_r;
    emit_data.job_outcome     = res_outc_r;
    emit_data.last            = res_last_r;
    emit_data.queued_count    = qlen_r;
    emit_data.active_count    = act_r;
    emit_data.completed_count = succ_r;
    emit_data.failed_count    = fail_r;
    if (res_jv_r) begin
      emit_data.out_job_id   = ent_r.id;
      emit_data.out_job_type = ent_r.jtype;
      emit_data.out_priority = ent_r.prio;
      emit_data.out_block_id = ent_r.block;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_IDLE;
      paused_r  <= 1'b0;
      qlen_r    <= '0;
      act_r     <= '0;
      next_id_r <= 32'd1;
      succ_r    <= '0;
      fail_r    <= '0;
      clr_r     <= 1'b0;
      for (int k = 0; k < QUEUE_DEPTH; k++) estat_r[k] <= ES_FREE;
    end else begin
      state_r <= state_nxt;
      if (cfg_we) paused_r <= cfg_wdata;
      unique case (state_r)
        S_IDLE: if (in_valid) cmd_r <= in_data;
        S_DISPATCH: begin
          len_r      <= qlen_r;
          i_r        <= '0;
          res_last_r <= 1'b1;
          res_jv_r   <= 1'b0;
          res_outc_r <= 1'b0;
          clr_r      <= 1'b0;
          priority case (cmd_r.func)
            FN_ENQ: begin
              if (full) begin
                res_status_r <= RS_FULL;
              end else begin
                res_status_r     <= RS_OK;
                res_jv_r         <= 1'b1;
                slot_r           <= free_idx;
                ent_r            <= e_wdata;
                estat_r[free_idx] <= ES_QUEUED;
                next_id_r        <= next_id_r + 32'd1;
                i_r              <= qlen_r;
              end
            end
            FN_DEQ:  res_status_r <= (qlen_r == '0) ? RS_EMPTY : RS_OK;
            FN_PROC: begin
              priority if (paused_r) res_status_r <= RS_NOT_OK;
              else if (qlen_r == '0) res_status_r <= RS_EMPTY;
              else res_status_r <= RS_OK;
            end
            FN_CLEAR: begin
              res_status_r <= RS_OK;
              if (qlen_r != '0) begin
                clr_r  <= 1'b1;
                qlen_r <= '0;
              end
            end
            default: res_status_r <= RS_NOT_OK;
          endcase
        end
        S_INS_RDO: if (i_r == '0) qlen_r <= qlen_r + 1'b1;
        S_INS_RDE: od_r <= o_rdata;
        S_INS_CHK: begin
          if (ins_stop) qlen_r <= qlen_r + 1'b1;
          else i_r <= i_r - 1'b1;
        end
        S_POP_O: slot_r <= o_rdata;
        S_POP_E: begin
          ent_r    <= e_rdata;
          res_jv_r <= 1'b1;
          i_r      <= CNT_W'(1);
          if (cmd_r.func == FN_DEQ) begin
            estat_r[slot_r] <= ES_ACTIVE;
            act_r           <= act_r + 1'b1;
          end else begin
            // process-one: pop, then complete at once; active count nets out
            estat_r[slot_r] <= ES_FREE;
            if (e_rdata.jtype > MAX_GOOD_TYPE) begin
              fail_r     <= fail_r + 32'd1;
              res_outc_r <= 1'b1;
            end else begin
              succ_r <= succ_r + 32'd1;
            end
          end
        end
        S_SH_RD: if (i_at_end) qlen_r <= qlen_r - 1'b1;
        S_SH_WR: i_r <= i_r + 1'b1;
        S_CP_RD: begin
          if (i_r != CNT_W'(QUEUE_DEPTH) && estat_r[i_r[IDX_W-1:0]] != ES_ACTIVE)
            i_r <= i_r + 1'b1;
        end
        S_CP_CHK: begin
          if (e_rdata.id == cmd_r.job_id) begin
            ent_r        <= e_rdata;
            res_jv_r     <= 1'b1;
            res_status_r <= RS_OK;
            res_outc_r   <= cmd_r.job_failed;
            estat_r[i_r[IDX_W-1:0]] <= ES_FREE;
            if (act_r != '0) act_r <= act_r - 1'b1;
            if (cmd_r.job_failed) fail_r <= fail_r + 32'd1;
            else succ_r <= succ_r + 32'd1;
          end else begin
            i_r <= i_r + 1'b1;
          end
        end
        S_CN_RDE: slot_r <= o_rdata;
        S_CN_CHK: begin
          i_r <= i_r + 1'b1;
          if (e_rdata.id == cmd_r.job_id) begin
            ent_r           <= e_rdata;
            res_jv_r        <= 1'b1;
            res_status_r    <= RS_OK;
            res_outc_r      <= 1'b1;
            estat_r[slot_r] <= ES_FREE;
          end
        end
        S_CL_RDE: slot_r <= o_rdata;
        S_CL_CAP: begin
          ent_r           <= e_rdata;
          res_jv_r        <= 1'b1;
          res_outc_r      <= 1'b1;
          estat_r[slot_r] <= ES_FREE;
          res_last_r      <= (i_r == len_r - 1'b1);
        end
        S_EMIT: if (emit_room && clr_r && !res_last_r) i_r <= i_r + 1'b1;
        default: ;
      endcase
    end
  end

  a_queue_bound: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_IDLE |-> (CNT_W + 1)'(qlen_r) + (CNT_W + 1)'(act_r)
                          <= (CNT_W + 1)'(QUEUE_DEPTH))
    else $error("queued plus active jobs exceed the pool");

  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> state_r == S_DISPATCH)
    else $error("accepted transfer not dispatched");

  a_clear_empties: assert property (@(posedge clk) disable iff (!rst_n)
    clr_r && state_r == S_EMIT |-> qlen_r == '0)
    else $error("queue not empty while flushing");

  a_single_ram_write: assert property (@(posedge clk) disable iff (!rst_n)
    e_we |-> !o_we && state_r == S_DISPATCH)
    else $error("entry write outside dispatch");

endmodule

`default_nettype wire

@@ hdl/priority_job_queue.sv @@
// priority_job_queue: top level; entry and order RAMs, sequencer, result register.
// Depends on pjq_pkg, pjq_ram, pjq_ctrl.
//
// Usage:
//   in_valid/in_ready/in_data carry one command (enqueue, dequeue, complete,
//   cancel, process-one, clear). out_valid/out_ready/out_data carry results;
//   each command gives one result, except clear on a non-empty queue, which
//   gives one per flushed job, the final one flagged by last.
//   cfg_we/cfg_wdata write the paused bit; write it only while idle.
//   One command at a time: in_ready is high only while the sequencer idles,
//   from the clock edge at which the final result is registered.
//   Time to out_valid grows with the RAM walks, one read per cycle: enqueue
//   walks up from the tail past each lower-priority job; dequeue and
//   process-one shift the rest of the queue up; complete scans the slots and
//   compares the id of each active one; cancel scans the order for the id,
//   then shifts the jobs behind it up; clear reads out one flushed job at a
//   time; a full, empty, refused or bad-code command goes straight to output.
//   A result waits in the sequencer until the output register is free or
//   being read, so a stalled receiver holds in_ready low.
//   Reset (rst_n low, synchronous) frees all entries, empties the queue,
//   zeroes counters, sets the next job id to 1 and clears paused.
`default_nettype none

module priority_job_queue
  import pjq_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic in_valid,
  output logic      in_ready,
  input  wire in_t  in_data,
  output logic      out_valid,
  input  wire logic out_ready,
  output out_t      out_data,
  input  wire logic cfg_we,
  input  wire logic cfg_wdata
);

  logic             emit_valid, emit_room;
  out_t             emit_data;
  logic             e_we, o_we;
  logic [IDX_W-1:0] e_waddr, e_raddr, o_waddr, o_wdata, o_raddr, o_rdata;
  entry_t           e_wdata, e_rdata;
  logic             out_valid_r;
  out_t             out_data_r;

  pjq_ram #(.WIDTH(ENTRY_W), .DEPTH(QUEUE_DEPTH)) u_entry_ram (
    .clk(clk), .we(e_we), .waddr(e_waddr), .wdata(e_wdata),
    .raddr(e_raddr), .rdata(e_rdata)
  );

  pjq_ram #(.WIDTH(IDX_W), .DEPTH(QUEUE_DEPTH)) u_order_ram (
    .clk(clk), .we(o_we), .waddr(o_waddr), .wdata(o_wdata),
    .raddr(o_raddr), .rdata(o_rdata)
  );

  pjq_ctrl u_ctrl (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
    .emit_valid(emit_valid), .emit_data(emit_data), .emit_room(emit_room),
    .e_we(e_we), .e_waddr(e_waddr), .e_wdata(e_wdata),
    .e_raddr(e_raddr), .e_rdata(e_rdata),
    .o_we(o_we), .o_waddr(o_waddr), .o_wdata(o_wdata),
    .o_raddr(o_raddr), .o_rdata(o_rdata)
  );

  assign emit_room = !out_valid_r || out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (emit_room) begin
      out_valid_r <= emit_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (emit_room && emit_valid) begin
      out_data_r <= emit_data;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

`default_nettype wire

@@ tb/tb_priority_job_queue.sv @@
// tb_priority_job_queue: self-checking testbench of the priority job queue.
// Depends on pjq_pkg and priority_job_queue; predicts every result and checks it.
`default_nettype none

module tb_priority_job_queue;
  import pjq_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int STALL_LIMIT = 20000;

  logic clk;
  logic rst_n;
  logic in_valid;
  logic in_ready;
  in_t  in_data;
  logic out_valid;
  logic out_ready;
  out_t out_data;
  logic cfg_we;
  logic cfg_wdata;

  priority_job_queue dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
    .cfg_we(cfg_we), .cfg_wdata(cfg_wdata)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // predictor state
  entry_t     job_pool [QUEUE_DEPTH];
  estat_t     pool_state [QUEUE_DEPTH];
  int         service_order [$];
  logic [CNT_W-1:0] running_jobs;
  logic [31:0] next_job_id;
  logic [31:0] good_total;
  logic [31:0] bad_total;
  logic        hold_proc;

  out_t expected_results [$];
  int   error_count;
  int   result_count;
  int   idle_cycles;
  bit   long_hold;
  bit   rx_random;

  task automatic clear_predictor();
    foreach (pool_state[i]) pool_state[i] = ES_FREE;
    service_order.delete();
    running_jobs = '0;
    next_job_id = 32'd1;
    good_total = '0;
    bad_total = '0;
    hold_proc = 1'b0;
  endtask

  function automatic out_t job_report(logic [1:0] st, int slot, logic outcome);
    out_t r;
    r = '0;
    r.status = st;
    if (slot >= 0) begin
      r.job_valid = 1'b1;
      r.out_job_id = job_pool[slot].id;
      r.out_job_type = job_pool[slot].jtype;
      r.out_priority = job_pool[slot].prio;
      r.out_block_id = job_pool[slot].block;
      r.job_outcome = outcome;
    end
    return r;
  endfunction

  task automatic predict_command(in_t cmd);
    out_t res [$];
    int slot;
    int pos;
    logic bad;
    slot = -1;
    case (cmd.func)
      FN_ENQ: begin
        foreach (pool_state[i])
          if (slot < 0 && pool_state[i] == ES_FREE) slot = i;
        if (slot < 0 || service_order.size() >= QUEUE_DEPTH) begin
          res.push_back(job_report(RS_FULL, -1, 1'b0));
        end else begin
          job_pool[slot] = '{id: next_job_id, jtype: cmd.job_type,
                             prio: cmd.priority_req, block: cmd.block_id};
          next_job_id++;
          pool_state[slot] = ES_QUEUED;
          pos = 0;
          while (pos < service_order.size() &&
                 job_pool[service_order[pos]].prio >= cmd.priority_req) pos++;
          service_order.insert(pos, slot);
          res.push_back(job_report(RS_OK, slot, 1'b0));
        end
      end
      FN_DEQ: begin
        if (service_order.size() == 0) begin
          res.push_back(job_report(RS_EMPTY, -1, 1'b0));
        end else begin
          slot = service_order.pop_front();
          pool_state[slot] = ES_ACTIVE;
          running_jobs++;
          res.push_back(job_report(RS_OK, slot, 1'b0));
        end
      end
      FN_CMPL: begin
        foreach (pool_state[i])
          if (slot < 0 && pool_state[i] == ES_ACTIVE && job_pool[i].id == cmd.job_id)
            slot = i;
        if (slot < 0) begin
          res.push_back(job_report(RS_NOT_OK, -1, 1'b0));
        end else begin
          pool_state[slot] = ES_FREE;
          running_jobs--;
          if (cmd.job_failed) bad_total++;
          else good_total++;
          res.push_back(job_report(RS_OK, slot, cmd.job_failed));
        end
      end
      FN_CANCEL: begin
        pos = -1;
        foreach (service_order[p])
          if (pos < 0 && job_pool[service_order[p]].id == cmd.job_id) pos = p;
        if (pos < 0) begin
          res.push_back(job_report(RS_NOT_OK, -1, 1'b0));
        end else begin
          slot = service_order[pos];
          service_order.delete(pos);
          pool_state[slot] = ES_FREE;
          res.push_back(job_report(RS_OK, slot, 1'b1));
        end
      end
      FN_PROC: begin
        if (hold_proc) begin
          res.push_back(job_report(RS_NOT_OK, -1, 1'b0));
        end else if (service_order.size() == 0) begin
          res.push_back(job_report(RS_EMPTY, -1, 1'b0));
        end else begin
          slot = service_order.pop_front();
          bad = job_pool[slot].jtype > MAX_GOOD_TYPE;
          pool_state[slot] = ES_FREE;
          if (bad) bad_total++;
          else good_total++;
          res.push_back(job_report(RS_OK, slot, bad));
        end
      end
      FN_CLEAR: begin
        if (service_order.size() == 0) res.push_back(job_report(RS_OK, -1, 1'b0));
        foreach (service_order[p]) begin
          pool_state[service_order[p]] = ES_FREE;
          res.push_back(job_report(RS_OK, service_order[p], 1'b1));
        end
        service_order.delete();
      end
      default: res.push_back(job_report(RS_NOT_OK, -1, 1'b0));
    endcase
    foreach (res[k]) begin
      res[k].last = (k == res.size() - 1);
      res[k].queued_count = CNT_W'(service_order.size());
      res[k].active_count = running_jobs;
      res[k].completed_count = good_total;
      res[k].failed_count = bad_total;
      expected_results.push_back(res[k]);
    end
  endtask

  // result checker
  always @(posedge clk) begin
    out_t exp_r;
    if (rst_n && out_valid && out_ready) begin
      result_count++;
      if (expected_results.size() == 0) begin
        $error("unexpected result transfer: %p", out_data);
        error_count++;
      end else begin
        exp_r = expected_results.pop_front();
        if (out_data.status !== exp_r.status) begin
          $error("status: expected %0d actual %0d", exp_r.status, out_data.status);
          error_count++;
        end
        if (out_data.job_valid !== exp_r.job_valid) begin
          $error("job_valid: expected %0d actual %0d", exp_r.job_valid, out_data.job_valid);
          error_count++;
        end
        if (out_data.out_job_id !== exp_r.out_job_id) begin
          $error("out_job_id: expected %0d actual %0d", exp_r.out_job_id, out_data.out_job_id);
          error_count++;
        end
        if (out_data.out_job_type !== exp_r.out_job_type) begin
          $error("out_job_type: expected %0d actual %0d", exp_r.out_job_type,
                 out_data.out_job_type);
          error_count++;
        end
        if (out_data.out_priority !== exp_r.out_priority) begin
          $error("out_priority: expected %0d actual %0d", exp_r.out_priority,
                 out_data.out_priority);
          error_count++;
        end
        if (out_data.out_block_id !== exp_r.out_block_id) begin
          $error("out_block_id: expected %0d actual %0d", exp_r.out_block_id,
                 out_data.out_block_id);
          error_count++;
        end
        if (out_data.job_outcome !== exp_r.job_outcome) begin
          $error("job_outcome: expected %0d actual %0d", exp_r.job_outcome,
                 out_data.job_outcome);
          error_count++;
        end
        if (out_data.last !== exp_r.last) begin
          $error("last: expected %0d actual %0d", exp_r.last, out_data.last);
          error_count++;
        end
        if (out_data.queued_count !== exp_r.queued_count) begin
          $error("queued_count: expected %0d actual %0d", exp_r.queued_count,
                 out_data.queued_count);
          error_count++;
        end
        if (out_data.active_count !== exp_r.active_count) begin
          $error("active_count: expected %0d actual %0d", exp_r.active_count,
                 out_data.active_count);
          error_count++;
        end
        if (out_data.completed_count !== exp_r.completed_count) begin
          $error("completed_count: expected %0d actual %0d", exp_r.completed_count,
                 out_data.completed_count);
          error_count++;
        end
        if (out_data.failed_count !== exp_r.failed_count) begin
          $error("failed_count: expected %0d actual %0d", exp_r.failed_count,
                 out_data.failed_count);
          error_count++;
        end
      end
    end
  end

  // receiver: random stalls, or a long hold-off when requested
  initial begin
    int gap;
    int held;
    out_ready = 1'b0;
    forever begin
      @(posedge clk);
      if (long_hold) begin
        out_ready <= 1'b0;
        for (held = 0; held < 400; held++) @(posedge clk);
        long_hold = 1'b0;
        out_ready <= 1'b1;
      end else if (rx_random && $urandom_range(0, 3) == 0) begin
        gap = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40) : $urandom_range(1, 3);
        out_ready <= 1'b0;
        repeat (gap) @(posedge clk);
        out_ready <= 1'b1;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  // watchdog on cycles without any transfer
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || long_hold) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles > STALL_LIMIT) begin
      $display("tb_priority_job_queue failed");
      $finish;
    end
  end

  task automatic send_command(in_t cmd, bit with_gaps = 1'b1);
    if (with_gaps && $urandom_range(0, 2) == 0)
      repeat (($urandom_range(0, 9) == 0) ? $urandom_range(10, 60) : $urandom_range(1, 3))
        @(posedge clk);
    in_valid <= 1'b1;
    in_data <= cmd;
    do @(posedge clk); while (!(in_valid && in_ready));
    predict_command(cmd);
    in_valid <= 1'b0;
    // the block is busy after a transfer, dispatching the command
    @(posedge clk);
  endtask

  function automatic in_t make_cmd(logic [2:0] f, logic [3:0] jt, logic [3:0] pr,
                                   logic [15:0] blk, logic [31:0] jid, logic jf);
    in_t c;
    c.func = f; c.job_type = jt; c.priority_req = pr;
    c.block_id = blk; c.job_id = jid; c.job_failed = jf;
    return c;
  endfunction

  function automatic in_t random_cmd(logic [2:0] f);
    in_t c;
    c = in_t'({$urandom, $urandom});
    c.func = f;
    return c;
  endfunction

  // waits for every expected result, then lets a pending clear walk finish
  task automatic drain();
    while (expected_results.size() != 0) @(posedge clk);
    repeat (80) @(posedge clk);
  endtask

  task automatic set_paused(logic v);
    drain();
    cfg_we <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
    hold_proc = v;
  endtask

  // pick an id that is queued, active, or neither
  function automatic logic [31:0] pick_id(estat_t want);
    int hits [$];
    foreach (pool_state[i]) if (pool_state[i] == want) hits.push_back(i);
    if (hits.size() == 0 || $urandom_range(0, 5) == 0) return $urandom;
    return job_pool[hits[$urandom_range(0, hits.size() - 1)]].id;
  endfunction

  task automatic test_directed();
    send_command(make_cmd(FN_DEQ, 0, 0, 0, 0, 0));
    send_command(make_cmd(FN_PROC, 0, 0, 0, 0, 0));
    send_command(make_cmd(FN_CLEAR, 0, 0, 0, 0, 0));
    send_command(make_cmd(FN_CMPL, 0, 0, 0, 32'hFFFF_FFFF, 1));
    send_command(make_cmd(FN_CANCEL, 0, 0, 0, 32'd1, 0));
    send_command(make_cmd(3'd6, 4'hF, 4'hF, 16'hFFFF, 32'hFFFF_FFFF, 1));
    send_command(make_cmd(3'd7, 0, 0, 0, 0, 0));
    // equal and mixed priorities, extremes of all fields, a bad kind
    send_command(make_cmd(FN_ENQ, 4'd0, 4'd0, 16'h0000, 0, 0));
    send_command(make_cmd(FN_ENQ, 4'd7, 4'hF, 16'hFFFF, 32'hFFFF_FFFF, 1));
    send_command(make_cmd(FN_ENQ, 4'hF, 4'hF, 16'hA5A5, 0, 0));
    send_command(make_cmd(FN_ENQ, 4'd3, 4'd0, 16'h5A5A, 0, 0));
    send_command(make_cmd(FN_DEQ, 0, 0, 0, 0, 0));
    send_command(make_cmd(FN_CMPL, 0, 0, 0, 32'd2, 1));
    send_command(make_cmd(FN_PROC, 0, 0, 0, 0, 0));
    send_command(make_cmd(FN_CANCEL, 0, 0, 0, 32'd4, 0));
    send_command(make_cmd(FN_DEQ, 0, 0, 0, 0, 0));
    send_command(make_cmd(FN_CANCEL, 0, 0, 0, 32'd1, 0));
    send_command(make_cmd(FN_CMPL, 0, 0, 0, 32'd1, 0));
    // fill the pool, overflow it, flush it
    repeat (17) send_command(random_cmd(FN_ENQ));
    send_command(make_cmd(FN_CLEAR, 0, 0, 0, 0, 0));
  endtask

  task automatic test_paused();
    set_paused(1'b1);
    send_command(random_cmd(FN_ENQ));
    send_command(make_cmd(FN_PROC, 0, 0, 0, 0, 0));
    set_paused(1'b0);
    send_command(make_cmd(FN_PROC, 0, 0, 0, 0, 0));
  endtask

  task automatic test_random(int n_items);
    in_t c;
    int sel;
    for (int n = 0; n < n_items; n++) begin
      sel = $urandom_range(0, 99);
      if (sel < 35) c = random_cmd(FN_ENQ);
      else if (sel < 50) c = random_cmd(FN_DEQ);
      else if (sel < 65) begin
        c = random_cmd(FN_CMPL);
        c.job_id = pick_id(ES_ACTIVE);
      end else if (sel < 77) begin
        c = random_cmd(FN_CANCEL);
        c.job_id = pick_id(ES_QUEUED);
      end else if (sel < 90) c = random_cmd(FN_PROC);
      else if (sel < 95) c = random_cmd(FN_CLEAR);
      else c = random_cmd(3'($urandom_range(6, 7)));
      send_command(c);
    end
  endtask

  // receiver holds off while the sender keeps offering commands
  task automatic test_backpressure();
    drain();
    long_hold = 1'b1;
    for (int n = 0; n < 12; n++) send_command(random_cmd(FN_ENQ), 1'b0);
    send_command(make_cmd(FN_CLEAR, 0, 0, 0, 0, 0), 1'b0);
    drain();
  endtask

  initial begin
    error_count = 0;
    result_count = 0;
    idle_cycles = 0;
    long_hold = 1'b0;
    rx_random = 1'b0;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_data = '0;
    cfg_we = 1'b0;
    cfg_wdata = 1'b0;
    clear_predictor();
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    rx_random = 1'b1;
    test_paused();
    test_backpressure();
    test_random(140);
    set_paused(1'b1);
    test_random(40);
    set_paused(1'b0);
    test_random(100);
    drain();
    $display("Ran directed edge cases, pause on/off, a long output stall and random traffic;");
    $display("%0d results checked, %0d mismatches.", result_count, error_count);
    if (error_count == 0) begin
      $display("tb_priority_job_queue passed");
    end else begin
      $display("tb_priority_job_queue failed");
    end
    $finish;
  end

  // leftover expectations are caught by drain, which never returns; the
  // watchdog then reports the failure
endmodule

`default_nettype wire
